[hw/rtl/dssc_pkg.sv]
`default_nettype none

package dssc_pkg;

    localparam int DEF_MAX_COLUMNS = 13;
    localparam int DEF_TYPE_BITS   = 7;
    localparam int DEF_COORD_BITS  = 5;

    localparam int COL_TYPE_W = 7;

    typedef struct packed {
        logic [COL_TYPE_W-1:0] column_type;
        logic                  last_column;
    } t_in_word;

    typedef struct packed {
        logic is_detecting;
        logic too_many_columns;
    } t_out_word;

endpackage

`default_nettype wire

[hw/rtl/distinct_subset_sum_checker_unit.sv]
`default_nettype none

// Collects column types one word at a time until a word marked last, then
// checks that all 2^k subset sums of the column vectors differ. Non-last
// words are taken back to back unless a result word waits on an output
// stall. A set ends with one result word. The check runs on a single sum
// memory with one read and one write port: it builds the sums, heap sorts
// them (each sift step compares the larger child with the root), and
// compares neighbors in one pass. The input is stalled for the whole
// check. A set with too many columns is answered at once.
module distinct_subset_sum_checker_unit
    import dssc_pkg::*;
#(
    parameter int MAX_COLUMNS = DEF_MAX_COLUMNS,
    parameter int TYPE_BITS   = DEF_TYPE_BITS,
    parameter int COORD_BITS  = DEF_COORD_BITS
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_in_valid,
    output logic       o_in_stall,
    input  t_in_word   i_in_word,
    output logic       o_out_valid,
    input  wire        i_out_stall,
    output t_out_word  o_out_word
);

    localparam int AW     = MAX_COLUMNS;
    localparam int CNT_W  = $clog2(MAX_COLUMNS + 1);
    localparam int IW     = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
    // coordinate fields plus headroom so a top-coordinate carry is kept
    localparam int SW     = COORD_BITS * (TYPE_BITS + 1) + 5;
    localparam int DEPTH  = 1 << AW;

    localparam logic [4:0] ST_IDLE = 5'd0,  ST_G0  = 5'd1,  ST_GRD = 5'd2,
                           ST_GWR  = 5'd3,  ST_BLD = 5'd4,  ST_SRT = 5'd5,
                           ST_X0   = 5'd6,  ST_X1  = 5'd7,  ST_X2  = 5'd8,
                           ST_X3   = 5'd9,  ST_SA  = 5'd10, ST_SB  = 5'd11,
                           ST_SR   = 5'd12, ST_SC  = 5'd13, ST_SW  = 5'd14,
                           ST_D0   = 5'd15, ST_D1  = 5'd16, ST_DRD = 5'd17,
                           ST_DCMP = 5'd18, ST_OUT = 5'd19;

    logic [SW-1:0] r_mem [DEPTH];
    logic [COL_TYPE_W-1:0] r_cols [MAX_COLUMNS];

    logic [4:0]       r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_ovf, n_ovf;
    logic [CNT_W-1:0] r_k, n_k;
    logic [CNT_W-1:0] r_ci, n_ci;
    logic [AW:0]      r_fill, n_fill;
    logic [AW:0]      r_j, n_j;
    logic [AW:0]      r_n, n_n;
    logic [AW:0]      r_i, n_i;
    logic [AW:0]      r_root, n_root;
    logic [AW:0]      r_lim, n_lim;
    logic             r_phase, n_phase;
    logic [SW-1:0]    r_rd;
    logic [SW-1:0]    r_a, n_a;
    logic [SW-1:0]    r_b, n_b;
    logic [SW-1:0]    r_t, n_t;
    logic             r_det, n_det;
    logic             r_out_valid, n_out_valid;
    t_out_word        r_out, n_out;

    logic             w_we;
    logic [AW-1:0]    w_waddr, w_raddr;
    logic [SW-1:0]    w_wdata;
    logic             w_acc;
    logic [AW+1:0]    w_child, w_child1;
    logic [SW-1:0]    w_vec;
    logic             w_pick_b;
    logic [SW-1:0]    w_big;
    logic [AW:0]      w_wsum;

    assign w_acc    = i_in_valid && !o_in_stall;
    assign w_child  = {r_root, 1'b1};
    assign w_child1 = w_child + {{(AW+1){1'b0}}, 1'b1};
    assign w_wsum   = r_fill + r_j;
    assign w_pick_b = (w_child1 < {1'b0, r_lim}) && (r_b > r_a);
    assign w_big    = w_pick_b ? r_b : r_a;

    // count coordinate is bit 0; type bit j lands on coordinate j+1
    always_comb begin
        logic [COL_TYPE_W-1:0] col;
        col   = r_cols[r_ci[IW-1:0]];
        w_vec = '0;
        w_vec[0] = 1'b1;
        for (int j = 0; j < TYPE_BITS; j++) begin
            w_vec[COORD_BITS * (j + 1)] = col[j];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_rd <= r_mem[w_raddr];
        if (w_acc && r_cnt < CNT_W'(MAX_COLUMNS)) begin
            r_cols[r_cnt[IW-1:0]] <= i_in_word.column_type;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_ovf       = r_ovf;
        n_k         = r_k;
        n_ci        = r_ci;
        n_fill      = r_fill;
        n_j         = r_j;
        n_n         = r_n;
        n_i         = r_i;
        n_root      = r_root;
        n_lim       = r_lim;
        n_phase     = r_phase;
        n_a         = r_a;
        n_b         = r_b;
        n_t         = r_t;
        n_det       = r_det;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;
        w_we        = 1'b0;
        w_waddr     = '0;
        w_wdata     = '0;
        w_raddr     = '0;
        o_in_stall  = (r_state != ST_IDLE) || (r_out_valid && i_out_stall);

        case (r_state)
            ST_IDLE: begin
                if (w_acc) begin
                    if (r_cnt < CNT_W'(MAX_COLUMNS)) begin
                        n_cnt = r_cnt + 1'b1;
                    end else begin
                        n_ovf = 1'b1;
                    end
                    if (i_in_word.last_column) begin
                        n_cnt = '0;
                        n_ovf = 1'b0;
                        if (r_ovf || r_cnt >= CNT_W'(MAX_COLUMNS)) begin
                            n_out.is_detecting     = 1'b0;
                            n_out.too_many_columns = 1'b1;
                            n_out_valid            = 1'b1;
                        end else begin
                            n_k     = r_cnt + 1'b1;
                            n_state = ST_G0;
                        end
                    end
                end
            end
            ST_G0: begin
                w_we    = 1'b1;
                w_waddr = '0;
                w_wdata = '0;
                n_fill  = (AW+1)'(1);
                n_j     = '0;
                n_ci    = '0;
                n_state = ST_GRD;
            end
            ST_GRD: begin
                w_raddr = r_j[AW-1:0];
                n_state = ST_GWR;
            end
            ST_GWR: begin
                w_we    = 1'b1;
                w_waddr = w_wsum[AW-1:0];
                w_wdata = r_rd + w_vec;
                n_j     = r_j + 1'b1;
                n_state = ST_GRD;
                if (r_j + 1'b1 == r_fill) begin
                    n_j    = '0;
                    n_fill = r_fill << 1;
                    n_ci   = r_ci + 1'b1;
                    if (r_ci + 1'b1 == r_k) begin
                        n_n     = r_fill << 1;
                        n_i     = r_fill;
                        n_state = ST_BLD;
                    end
                end
            end
            ST_BLD: begin
                if (r_i == '0) begin
                    n_i     = r_n - 1'b1;
                    n_state = ST_SRT;
                end else begin
                    n_root  = r_i - 1'b1;
                    n_lim   = r_n;
                    n_phase = 1'b0;
                    n_i     = r_i - 1'b1;
                    n_state = ST_SA;
                end
            end
            ST_SRT: begin
                n_state = (r_i == '0) ? ST_D0 : ST_X0;
            end
            ST_X0: begin
                w_raddr = '0;
                n_state = ST_X1;
            end
            ST_X1: begin
                n_t     = r_rd;
                w_raddr = r_i[AW-1:0];
                n_state = ST_X2;
            end
            ST_X2: begin
                w_we    = 1'b1;
                w_waddr = '0;
                w_wdata = r_rd;
                n_state = ST_X3;
            end
            ST_X3: begin
                w_we    = 1'b1;
                w_waddr = r_i[AW-1:0];
                w_wdata = r_t;
                n_root  = '0;
                n_lim   = r_i;
                n_phase = 1'b1;
                n_i     = r_i - 1'b1;
                n_state = ST_SA;
            end
            ST_SA: begin
                if (w_child >= {1'b0, r_lim}) begin
                    n_state = r_phase ? ST_SRT : ST_BLD;
                end else begin
                    w_raddr = w_child[AW-1:0];
                    n_state = ST_SB;
                end
            end
            ST_SB: begin
                n_a     = r_rd;
                w_raddr = w_child1[AW-1:0];
                n_state = ST_SR;
            end
            ST_SR: begin
                n_b     = r_rd;
                w_raddr = r_root[AW-1:0];
                n_state = ST_SC;
            end
            ST_SC: begin
                if (r_rd >= w_big) begin
                    n_state = r_phase ? ST_SRT : ST_BLD;
                end else begin
                    w_we    = 1'b1;
                    w_waddr = r_root[AW-1:0];
                    w_wdata = w_big;
                    n_t     = r_rd;
                    n_root  = w_pick_b ? w_child1[AW:0] : w_child[AW:0];
                    n_state = ST_SW;
                end
            end
            ST_SW: begin
                w_we    = 1'b1;
                w_waddr = r_root[AW-1:0];
                w_wdata = r_t;
                n_state = ST_SA;
            end
            ST_D0: begin
                w_raddr = '0;
                n_state = ST_D1;
            end
            ST_D1: begin
                n_t     = r_rd;
                n_j     = (AW+1)'(1);
                n_state = ST_DRD;
            end
            ST_DRD: begin
                w_raddr = r_j[AW-1:0];
                n_state = ST_DCMP;
            end
            ST_DCMP: begin
                n_t     = r_rd;
                n_j     = r_j + 1'b1;
                n_state = ST_DRD;
                if (r_rd == r_t) begin
                    n_det   = 1'b0;
                    n_state = ST_OUT;
                end else if (r_j == r_n - 1'b1) begin
                    n_det   = 1'b1;
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out.is_detecting     = r_det;
                    n_out.too_many_columns = 1'b0;
                    n_out_valid            = 1'b1;
                    n_state                = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_ovf       <= n_ovf;
            r_out_valid <= n_out_valid;
        end
        r_k     <= n_k;
        r_ci    <= n_ci;
        r_fill  <= n_fill;
        r_j     <= n_j;
        r_n     <= n_n;
        r_i     <= n_i;
        r_root  <= n_root;
        r_lim   <= n_lim;
        r_phase <= n_phase;
        r_a     <= n_a;
        r_b     <= n_b;
        r_t     <= n_t;
        r_det   <= n_det;
        r_out   <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

endmodule

`default_nettype wire

[tb/sv/tb_distinct_subset_sum_checker_unit.sv]
`default_nettype none

module tb_distinct_subset_sum_checker_unit;
    import dssc_pkg::*;

    localparam int MAX_COLS    = DEF_MAX_COLUMNS;
    localparam int TBITS       = DEF_TYPE_BITS;
    localparam int CBITS       = DEF_COORD_BITS;
    localparam int CYCLE_LIMIT = 6_000_000;
    localparam int HOLD_CYCLES = 400;

    typedef struct {
        t_in_word  word;
        bit        known;
        t_out_word result;
    } t_row;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_stall;
    t_in_word  i_in_word;
    logic      o_out_valid;
    logic      i_out_stall;
    t_out_word o_out_word;

    distinct_subset_sum_checker_unit u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_word  (i_in_word),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_word (o_out_word)
    );

    // predictor state
    logic [TBITS-1:0] set_cols[$];
    bit               set_overflow;
    t_out_word        verdict_q[$];
    bit               typed_known_q[$];
    t_out_word        typed_result_q[$];

    int  err_count;
    int  cycles;
    int  sets_sent, overflow_sets, words_sent;
    bit  quiet;
    bit  hold_go, hold_done;
    t_row rows[$];

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("FAILURE");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d expected %0d (cycle %0d)", what, got, want, cycles);
        err_count++;
    endtask

    function automatic logic [63:0] column_vector(input logic [TBITS-1:0] t);
        logic [63:0] v;
        v = 64'd1;
        for (int j = 0; j < TBITS; j++)
            if (t[j]) v += 64'd1 << (CBITS * (j + 1));
        return v;
    endfunction

    function automatic bit sums_distinct(input logic [TBITS-1:0] cols[$]);
        logic [63:0] sums[$];
        bit          seen[logic [63:0]];
        int          n;
        logic [63:0] d;
        sums.push_back(64'd0);
        foreach (cols[i]) begin
            d = column_vector(cols[i]);
            n = sums.size();
            for (int j = 0; j < n; j++) sums.push_back(sums[j] + d);
        end
        foreach (sums[i]) begin
            if (seen.exists(sums[i])) return 1'b0;
            seen[sums[i]] = 1'b1;
        end
        return 1'b1;
    endfunction

    task automatic predict_word(input t_in_word w);
        t_out_word r;
        bit        known;
        t_out_word typed;
        known = typed_known_q.pop_front();
        typed = typed_result_q.pop_front();
        if (set_cols.size() < MAX_COLS) set_cols.push_back(w.column_type);
        else set_overflow = 1'b1;
        if (w.last_column) begin
            if (set_overflow) begin
                r.is_detecting     = 1'b0;
                r.too_many_columns = 1'b1;
            end else begin
                r.is_detecting     = sums_distinct(set_cols);
                r.too_many_columns = 1'b0;
            end
            if (known) begin
                if (typed != r) report_mismatch("table vs predictor", typed, r);
                r = typed;
            end
            verdict_q.push_back(r);
            set_cols.delete();
            set_overflow = 1'b0;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && !o_in_stall) predict_word(i_in_word);
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (verdict_q.size() == 0) begin
                report_mismatch("unexpected word", o_out_word, 0);
            end else begin
                if (o_out_word.is_detecting != verdict_q[0].is_detecting)
                    report_mismatch("is_detecting", o_out_word.is_detecting,
                                    verdict_q[0].is_detecting);
                if (o_out_word.too_many_columns != verdict_q[0].too_many_columns)
                    report_mismatch("too_many_columns", o_out_word.too_many_columns,
                                    verdict_q[0].too_many_columns);
                void'(verdict_q.pop_front());
            end
        end
    end

    function automatic int pick_gap();
        int r;
        if ($urandom_range(0, 15) == 0) quiet = ~quiet;
        if (quiet) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // receiver: one long hold-off once a result word is waiting, otherwise random stalls
    initial begin
        int g;
        i_out_stall = 1'b1;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_go && !hold_done) begin
                i_out_stall <= 1'b1;
                while (!o_out_valid) @(negedge i_clk);
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_done = 1'b1;
                i_out_stall <= 1'b0;
            end else begin
                g = pick_gap();
                i_out_stall <= (g > 0);
                if (g > 1) repeat (g - 1) @(negedge i_clk);
            end
        end
    end

    task automatic send_word(input t_in_word w, input bit known, input t_out_word res);
        int g;
        g = pick_gap();
        typed_known_q.push_back(known);
        typed_result_q.push_back(res);
        if (g > 0) begin
            i_in_valid <= 1'b0;
            repeat (g) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        @(negedge i_clk);
        words_sent++;
        if (w.last_column) sets_sent++;
    endtask

    function automatic void add_row(input logic [TBITS-1:0] t, input bit last,
                                    input bit known = 0, input bit det = 0,
                                    input bit many = 0);
        t_row r;
        r.word.column_type            = t;
        r.word.last_column            = last;
        r.known                       = known;
        r.result.is_detecting         = det;
        r.result.too_many_columns     = many;
        rows.push_back(r);
    endfunction

    task automatic send_set(input int k, input bit dup);
        t_in_word w;
        logic [TBITS-1:0] first;
        first = TBITS'($urandom_range(0, 127));
        if (k > MAX_COLS) overflow_sets++;
        for (int i = 0; i < k; i++) begin
            w.column_type = (dup && i == k - 1) ? first : TBITS'($urandom_range(0, 127));
            if (i == 0) w.column_type = first;
            w.last_column = (i == k - 1);
            send_word(w, 1'b0, '0);
        end
    endtask

    initial begin
        int        k, rnd_words;
        t_in_word  w;
        err_count = 0; cycles = 0; quiet = 0; hold_go = 0; hold_done = 0;
        sets_sent = 0; overflow_sets = 0; words_sent = 0; set_overflow = 0;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_word = '0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // single columns, extremes, repeated column, all-ones with zero, types 1, 2, 3
        add_row(7'd0,   1, 1, 1, 0);
        add_row(7'd127, 1, 1, 1, 0);
        add_row(7'd5,   0);
        add_row(7'd5,   1, 1, 0, 0);
        add_row(7'd127, 0);
        add_row(7'd0,   1, 1, 1, 0);
        add_row(7'd1,   0);
        add_row(7'd2,   0);
        add_row(7'd3,   1);
        // one column past the maximum: answered as overflow
        for (int i = 0; i <= MAX_COLS; i++)
            add_row(TBITS'(i * 9), i == MAX_COLS, i == MAX_COLS, 0, 1);
        overflow_sets++;
        foreach (rows[i]) send_word(rows[i].word, rows[i].known, rows[i].result);
        // one full-size set, the slow case
        for (int i = 0; i < MAX_COLS; i++) begin
            w.column_type = TBITS'(1 << (i % TBITS)) ^ TBITS'(i);
            w.last_column = (i == MAX_COLS - 1);
            send_word(w, 1'b0, '0);
        end

        hold_go = 1'b1;
        rnd_words = 0;
        while (rnd_words < 64) begin
            if ($urandom_range(0, 11) == 0) k = $urandom_range(MAX_COLS + 1, 16);
            else if ($urandom_range(0, 7) == 0) k = $urandom_range(7, 9);
            else k = $urandom_range(1, 6);
            send_set(k, k > 1 && $urandom_range(0, 3) == 0);
            rnd_words += k;
        end
        i_in_valid <= 1'b0;

        while (verdict_q.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);

        $display("sent %0d words in %0d sets (%0d over the column limit)",
                 words_sent, sets_sent, overflow_sets);
        $display("included a full %0d-column set and a %0d-cycle output hold-off",
                 MAX_COLS, HOLD_CYCLES);
        if (err_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("%0d mismatches", err_count);
            $display("FAILURE");
        end
        $finish;
    end

endmodule

`default_nettype wire
